// ===== rtl/core/qrv_pkg.sv =====
// ============================================================================
// Quaternion vector rotation package
// Widths, stage payload types and result constants shared by the pipeline.
// ============================================================================
package qrv_pkg;

  // Field widths.
  localparam int QW  = 16;        // quaternion part, Q1.14
  localparam int VW  = 32;        // vector part, Q15.16
  localparam int VHW = 16;        // half of a vector part
  localparam int MW  = 34;        // scaled rotation matrix entry
  localparam int NW  = 33;        // squared norm
  localparam int DW  = NW + 1;    // divisor, twice the squared norm
  localparam int QB  = 34;        // quotient bits of the biased division
  localparam int AW  = DW + QB;   // biased dividend
  localparam int PHW = MW + VHW;  // matrix entry times signed upper half
  localparam int PLW = MW + VHW + 1; // matrix entry times unsigned lower half
  localparam int HW  = PHW + 2;   // sum of three upper products
  localparam int LW  = PLW + 2;   // sum of three lower products
  localparam int XW  = AW + 2;    // signed working width of the dividend
  localparam int RW  = QB + 1;    // signed result before saturation

  // Bias added to the quotient so the divider only sees positive values.
  localparam logic signed [RW-1:0] ResOffset = RW'(1) <<< (QB - 1);
  localparam logic signed [RW-1:0] ResMax    = (RW'(1) <<< (VW - 1)) - RW'(1);
  localparam logic signed [RW-1:0] ResMin    = -(RW'(1) <<< (VW - 1));

  typedef struct packed {
    logic [QW-1:0] w;
    logic [QW-1:0] x;
    logic [QW-1:0] y;
    logic [QW-1:0] z;
  } quat_t;

  typedef struct packed {
    logic [2:0][VW-1:0] v;
  } vec_t;

  typedef struct packed {
    logic [2:0][2:0][MW-1:0] m;
    logic [NW-1:0]           n;
    logic [2:0][VHW-1:0]     vh;
    logic [2:0][VHW-1:0]     vl;
  } mat_t;

  typedef struct packed {
    logic [2:0][AW-1:0] a;
    logic [DW-1:0]      d;
    logic               degen;
  } div_in_t;

  typedef struct packed {
    logic [2:0][QB-1:0] q;
    logic               degen;
  } div_out_t;

endpackage

// ===== rtl/core/qrv_if.sv =====
// ============================================================================
// Quaternion vector rotation channels
// Input and output word channels with valid/ready handshake.
// ============================================================================
interface qrv_in_if import qrv_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic signed [QW-1:0] quat_w;
  logic signed [QW-1:0] quat_x;
  logic signed [QW-1:0] quat_y;
  logic signed [QW-1:0] quat_z;
  logic signed [VW-1:0] vec_x;
  logic signed [VW-1:0] vec_y;
  logic signed [VW-1:0] vec_z;

  modport source (output valid, quat_w, quat_x, quat_y, quat_z, vec_x, vec_y, vec_z,
                  input ready);
  modport sink (input valid, quat_w, quat_x, quat_y, quat_z, vec_x, vec_y, vec_z,
                output ready);
endinterface

interface qrv_out_if import qrv_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic signed [VW-1:0] rot_x;
  logic signed [VW-1:0] rot_y;
  logic signed [VW-1:0] rot_z;
  logic                 degenerate;

  modport source (output valid, rot_x, rot_y, rot_z, degenerate, input ready);
  modport sink (input valid, rot_x, rot_y, rot_z, degenerate, output ready);
endinterface

// ===== rtl/core/qrv_matrix.sv =====
// ============================================================================
// Rotation matrix stages
// Forms the quaternion products, then the rotation matrix scaled by the
// squared norm, and splits the vector into halves. Two register stages.
// ============================================================================
module qrv_matrix import qrv_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  valid_i,
  output logic  ready_o,
  input  quat_t quat_i,
  input  vec_t  vec_i,
  output logic  valid_o,
  input  logic  ready_i,
  output mat_t  mat_o
);

  logic signed [QW-1:0]   w, x, y, z;
  logic signed [2*QW-1:0] ww_q, xx_q, yy_q, zz_q, xy_q, wz_q, xz_q, wy_q, yz_q, wx_q;
  vec_t                   vec_q;
  logic                   v1_q, v2_q;
  logic                   en1, en2;
  mat_t                   mat_d, mat_q;

  // Stage enables: a stage loads when it is empty or its word moves on.
  assign en2     = !v2_q || ready_i;
  assign en1     = !v1_q || en2;
  assign ready_o = en1;

  assign w = $signed(quat_i.w);
  assign x = $signed(quat_i.x);
  assign y = $signed(quat_i.y);
  assign z = $signed(quat_i.z);

  // Stage 1: the ten pairwise products of the quaternion parts.
  always_ff @(posedge clk_i) begin
    if (en1 && valid_i) begin
      ww_q  <= w * w;
      xx_q  <= x * x;
      yy_q  <= y * y;
      zz_q  <= z * z;
      xy_q  <= x * y;
      wz_q  <= w * z;
      xz_q  <= x * z;
      wy_q  <= w * y;
      yz_q  <= y * z;
      wx_q  <= w * x;
      vec_q <= vec_i;
    end
  end

  // Stage 2: matrix entries scaled by the squared norm.
  always_comb begin
    mat_d.m[0][0] = MW'(ww_q) + MW'(xx_q) - MW'(yy_q) - MW'(zz_q);
    mat_d.m[0][1] = (MW'(xy_q) - MW'(wz_q)) <<< 1;
    mat_d.m[0][2] = (MW'(xz_q) + MW'(wy_q)) <<< 1;
    mat_d.m[1][0] = (MW'(xy_q) + MW'(wz_q)) <<< 1;
    mat_d.m[1][1] = MW'(ww_q) - MW'(xx_q) + MW'(yy_q) - MW'(zz_q);
    mat_d.m[1][2] = (MW'(yz_q) - MW'(wx_q)) <<< 1;
    mat_d.m[2][0] = (MW'(xz_q) - MW'(wy_q)) <<< 1;
    mat_d.m[2][1] = (MW'(yz_q) + MW'(wx_q)) <<< 1;
    mat_d.m[2][2] = MW'(ww_q) - MW'(xx_q) - MW'(yy_q) + MW'(zz_q);
    mat_d.n = NW'($unsigned(ww_q)) + NW'($unsigned(xx_q)) +
              NW'($unsigned(yy_q)) + NW'($unsigned(zz_q));
    for (int j = 0; j < 3; j++) begin
      mat_d.vh[j] = vec_q.v[j][VW-1:VHW];
      mat_d.vl[j] = vec_q.v[j][VHW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en2 && v1_q) begin
      mat_q <= mat_d;
    end
  end

  // Valid bits travel with the words.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (en1) v1_q <= valid_i;
      if (en2) v2_q <= v1_q;
    end
  end

  assign valid_o = v2_q;
  assign mat_o   = mat_q;

endmodule

// ===== rtl/core/qrv_apply.sv =====
// ============================================================================
// Matrix apply stages
// Multiplies the scaled matrix by the vector halves, sums the rows and forms
// the biased, rounded dividend for each lane. Three register stages.
// ============================================================================
module qrv_apply import qrv_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    valid_i,
  output logic    ready_o,
  input  mat_t    mat_i,
  output logic    valid_o,
  input  logic    ready_i,
  output div_in_t div_o
);

  logic signed [PHW-1:0] ph_q [3][3];
  logic signed [PLW-1:0] pl_q [3][3];
  logic signed [HW-1:0]  hi_q [3];
  logic signed [LW-1:0]  lo_q [3];
  logic [NW-1:0]         n3_q, n4_q;
  logic                  v3_q, v4_q, v5_q;
  logic                  en3, en4, en5;
  div_in_t               div_d, div_q;
  logic signed [XW-1:0]  num_c [3];

  assign en5     = !v5_q || ready_i;
  assign en4     = !v4_q || en5;
  assign en3     = !v3_q || en4;
  assign ready_o = en3;

  // Stage 3: one product per matrix entry and vector half.
  always_ff @(posedge clk_i) begin
    if (en3 && valid_i) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          ph_q[i][j] <= $signed(mat_i.m[i][j]) * $signed(mat_i.vh[j]);
          pl_q[i][j] <= $signed(mat_i.m[i][j]) * $signed({1'b0, mat_i.vl[j]});
        end
      end
      n3_q <= mat_i.n;
    end
  end

  // Stage 4: row sums of the upper and lower halves.
  always_ff @(posedge clk_i) begin
    if (en4 && v3_q) begin
      for (int i = 0; i < 3; i++) begin
        hi_q[i] <= HW'(ph_q[i][0]) + HW'(ph_q[i][1]) + HW'(ph_q[i][2]);
        lo_q[i] <= LW'(pl_q[i][0]) + LW'(pl_q[i][1]) + LW'(pl_q[i][2]);
      end
      n4_q <= n3_q;
    end
  end

  // Stage 5: dividend 2*num + n, plus the divisor shifted up so the quotient
  // stays positive; the divisor is 2*n, which turns floor division into
  // rounding to nearest.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      num_c[i] = (XW'(hi_q[i]) <<< (VHW + 1)) + (XW'(lo_q[i]) <<< 1) +
                 $signed(XW'(n4_q)) + $signed(XW'(n4_q) << QB);
      div_d.a[i] = num_c[i][AW-1:0];
    end
    div_d.d     = {n4_q, 1'b0};
    div_d.degen = (n4_q == '0);
  end

  always_ff @(posedge clk_i) begin
    if (en5 && v4_q) begin
      div_q <= div_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      if (en3) v3_q <= valid_i;
      if (en4) v4_q <= v3_q;
      if (en5) v5_q <= v4_q;
    end
  end

  assign valid_o = v5_q;
  assign div_o   = div_q;

endmodule

// ===== rtl/core/qrv_div.sv =====
// ============================================================================
// Pipelined divider
// Three restoring division lanes with a shared divisor, one quotient bit
// per register stage.
// ============================================================================
module qrv_div import qrv_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     valid_i,
  output logic     ready_o,
  input  div_in_t  div_i,
  output logic     valid_o,
  input  logic     ready_i,
  output div_out_t div_o
);

  logic          v_q   [QB];
  logic [DW-1:0] r_q   [QB][3];
  logic [QB-1:0] s_q   [QB][3];
  logic [DW-1:0] d_q   [QB];
  logic          g_q   [QB];
  logic          en    [QB];
  logic          v_src [QB];
  logic [DW-1:0] d_src [QB];
  logic          g_src [QB];
  logic [DW-1:0] r_src [QB][3];
  logic [QB-1:0] s_src [QB][3];
  logic [DW:0]   t_c   [QB][3];
  logic [DW:0]   diff_c [QB][3];
  logic [DW-1:0] r_d   [QB][3];
  logic [QB-1:0] s_d   [QB][3];

  // Enable chain from the output back to the input.
  always_comb begin
    for (int k = QB - 1; k >= 0; k--) begin
      if (k == QB - 1) begin
        en[k] = !v_q[k] || ready_i;
      end else begin
        en[k] = !v_q[k] || en[k+1];
      end
    end
  end

  assign ready_o = en[0];

  // One compare and subtract per stage; the dividend shifts out of the low
  // word while quotient bits shift in.
  always_comb begin
    for (int k = 0; k < QB; k++) begin
      if (k == 0) begin
        v_src[k] = valid_i;
        d_src[k] = div_i.d;
        g_src[k] = div_i.degen;
      end else begin
        v_src[k] = v_q[k-1];
        d_src[k] = d_q[k-1];
        g_src[k] = g_q[k-1];
      end
      for (int l = 0; l < 3; l++) begin
        if (k == 0) begin
          r_src[k][l] = div_i.a[l][AW-1:QB];
          s_src[k][l] = div_i.a[l][QB-1:0];
        end else begin
          r_src[k][l] = r_q[k-1][l];
          s_src[k][l] = s_q[k-1][l];
        end
        t_c[k][l]    = {r_src[k][l], s_src[k][l][QB-1]};
        diff_c[k][l] = t_c[k][l] - {1'b0, d_src[k]};
        if (t_c[k][l] >= {1'b0, d_src[k]}) begin
          r_d[k][l] = diff_c[k][l][DW-1:0];
          s_d[k][l] = {s_src[k][l][QB-2:0], 1'b1};
        end else begin
          r_d[k][l] = t_c[k][l][DW-1:0];
          s_d[k][l] = {s_src[k][l][QB-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < QB; k++) begin
      if (en[k] && v_src[k]) begin
        d_q[k] <= d_src[k];
        g_q[k] <= g_src[k];
        for (int l = 0; l < 3; l++) begin
          r_q[k][l] <= r_d[k][l];
          s_q[k][l] <= s_d[k][l];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < QB; k++) v_q[k] <= 1'b0;
    end else begin
      for (int k = 0; k < QB; k++) begin
        if (en[k]) v_q[k] <= v_src[k];
      end
    end
  end

  assign valid_o = v_q[QB-1];
  always_comb begin
    for (int l = 0; l < 3; l++) div_o.q[l] = s_q[QB-1][l];
    div_o.degen = g_q[QB-1];
  end

  // The final remainder of a non-degenerate word stays below the divisor.
  a_rem_below_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[QB-1] && !g_q[QB-1] |-> (r_q[QB-1][0] < d_q[QB-1]) &&
                                (r_q[QB-1][1] < d_q[QB-1]) &&
                                (r_q[QB-1][2] < d_q[QB-1]))
    else $error("divider remainder not below divisor");

endmodule

// ===== rtl/core/quaternion_rotate_vector.sv =====
// ============================================================================
// Quaternion vector rotation
// Rotates a Q15.16 vector by a Q1.14 quaternion of any length, q*v*q^-1.
// ============================================================================
// Usage:
//   in_i carries one word per item: a quaternion (quat_w..quat_z) and a
//   vector (vec_x..vec_z). out_o carries the rotated vector rot_x..rot_z,
//   rounded to nearest and saturated, plus the degenerate flag, set with a
//   zero vector when all four quaternion parts are zero.
//   Both channels move a word on a clock edge with valid and ready high.
// Pipeline:
//   A word passes 40 register stages: two stages of products and matrix
//   terms, three stages of matrix apply and dividend, 34 divider stages that
//   each produce one quotient bit, and the output register. One word is
//   accepted every cycle while out_o is not stalled.
// Reset and stalls:
//   Reset empties the pipeline; there is no other state. When out_o stalls,
//   stages fill up behind it one by one and in_i.ready drops only once every
//   stage holds a word. No word is lost or repeated.
// ============================================================================
module quaternion_rotate_vector import qrv_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  qrv_in_if.sink      in_i,
  qrv_out_if.source   out_o
);

  quat_t                quat_c;
  vec_t                 vec_c;
  mat_t                 mat_c;
  div_in_t              divin_c;
  div_out_t             divout_c;
  logic                 mat_valid, mat_ready;
  logic                 app_valid, app_ready;
  logic                 div_valid, div_ready;
  logic                 ov_q;
  logic                 en_o;
  logic signed [RW-1:0] res_c [3];
  logic [VW-1:0]        rot_d [3];
  logic [VW-1:0]        rot_q [3];
  logic                 dg_q;

  assign quat_c.w   = in_i.quat_w;
  assign quat_c.x   = in_i.quat_x;
  assign quat_c.y   = in_i.quat_y;
  assign quat_c.z   = in_i.quat_z;
  assign vec_c.v[0] = in_i.vec_x;
  assign vec_c.v[1] = in_i.vec_y;
  assign vec_c.v[2] = in_i.vec_z;

  qrv_matrix u_matrix (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_i.valid),
    .ready_o (in_i.ready),
    .quat_i  (quat_c),
    .vec_i   (vec_c),
    .valid_o (mat_valid),
    .ready_i (mat_ready),
    .mat_o   (mat_c)
  );

  qrv_apply u_apply (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (mat_valid),
    .ready_o (mat_ready),
    .mat_i   (mat_c),
    .valid_o (app_valid),
    .ready_i (app_ready),
    .div_o   (divin_c)
  );

  qrv_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (app_valid),
    .ready_o (app_ready),
    .div_i   (divin_c),
    .valid_o (div_valid),
    .ready_i (div_ready),
    .div_o   (divout_c)
  );

  assign en_o      = !ov_q || out_o.ready;
  assign div_ready = en_o;

  // Remove the quotient bias and saturate to the vector range; a degenerate word gives zero.
  always_comb begin
    for (int l = 0; l < 3; l++) begin
      res_c[l] = $signed({1'b0, divout_c.q[l]}) - ResOffset;
      if (divout_c.degen) begin
        rot_d[l] = '0;
      end else if (res_c[l] > ResMax) begin
        rot_d[l] = ResMax[VW-1:0];
      end else if (res_c[l] < ResMin) begin
        rot_d[l] = ResMin[VW-1:0];
      end else begin
        rot_d[l] = res_c[l][VW-1:0];
      end
    end
  end

  // Output register.
  always_ff @(posedge clk_i) begin
    if (en_o && div_valid) begin
      for (int l = 0; l < 3; l++) rot_q[l] <= rot_d[l];
      dg_q <= divout_c.degen;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (en_o) begin
      ov_q <= div_valid;
    end
  end

  assign out_o.valid      = ov_q;
  assign out_o.rot_x      = rot_q[0];
  assign out_o.rot_y      = rot_q[1];
  assign out_o.rot_z      = rot_q[2];
  assign out_o.degenerate = dg_q;

  // A degenerate word always carries a zero vector.
  a_degen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.degenerate |->
      (out_o.rot_x == '0) && (out_o.rot_y == '0) && (out_o.rot_z == '0))
    else $error("degenerate word with nonzero vector");

  // With the output register empty the whole pipeline can advance.
  a_ready_when_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_o.valid |-> in_i.ready)
    else $error("input stalled while output register empty");

endmodule
